FILE: rtl/bclp_pkg.sv
// Package for the button click and long-press qualifier.
// Holds shared widths, button codes, register map and the queue entry type.
// No dependencies.
package bclp_pkg;

  localparam int unsigned TS_W  = 40;
  localparam int unsigned LPT_W = 24;
  localparam int unsigned SN_W  = 3;
  localparam int unsigned AGR_W = 3;
  localparam int unsigned BTN_W = 2;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  localparam logic [AGR_W-1:0] AGREE_MAX = 3'd4;

  localparam logic [BTN_W-1:0] BTN_NONE  = 2'd0;
  localparam logic [BTN_W-1:0] BTN_LEFT  = 2'd1;
  localparam logic [BTN_W-1:0] BTN_RIGHT = 2'd2;

  localparam logic [LPT_W-1:0] LPT_RESET = 24'd500000;
  localparam logic [SN_W-1:0]  SN_RESET  = 3'd2;

  localparam logic REG_LPT = 1'b0;
  localparam logic REG_SN  = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef struct packed {
    logic             valid;
    logic [BTN_W-1:0] bits;
  } bclp_evt_t;

endpackage

FILE: rtl/bclp_front.sv
// Front end: debounces the raw level and classifies each poll into a click event.
// Depends on bclp_pkg.
module bclp_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           raw_level_i,
  input  logic [bclp_pkg::TS_W-1:0]      now_us_i,
  input  logic                           link_ready_i,
  input  logic [bclp_pkg::LPT_W-1:0]     long_press_time_i,
  input  logic [bclp_pkg::SN_W-1:0]      stable_needed_i,
  output bclp_pkg::bclp_evt_t            push_o
);

  logic                          last_raw_q, last_raw_d;
  logic [bclp_pkg::AGR_W-1:0]    agree_q, agree_d;
  logic                          prev_stable_q, prev_stable_d;
  logic                          armed_q, armed_d;
  logic [bclp_pkg::TS_W-1:0]     stamp_q, stamp_d;

  logic                          stable;
  logic                          press_edge;
  logic                          release_edge;
  logic                          armed_eff;
  logic [bclp_pkg::TS_W-1:0]     stamp_eff;
  logic [bclp_pkg::TS_W-1:0]     held;
  logic                          long_hit;
  logic                          fire_right;
  logic                          fire_left;

  always_comb begin
    if (raw_level_i == last_raw_q) begin
      agree_d = (agree_q < bclp_pkg::AGREE_MAX) ? agree_q + 3'd1 : agree_q;
    end else begin
      agree_d = '0;
    end
    last_raw_d   = raw_level_i;
    stable       = (agree_d >= stable_needed_i) ? raw_level_i : prev_stable_q;
    press_edge   = prev_stable_q & ~stable;
    release_edge = ~prev_stable_q & stable;
    armed_eff    = armed_q | press_edge;
    stamp_eff    = press_edge ? now_us_i : stamp_q;
    held         = now_us_i - stamp_eff;
    long_hit     = held >= {{(bclp_pkg::TS_W-bclp_pkg::LPT_W){1'b0}}, long_press_time_i};
    fire_right   = armed_eff & ~stable & long_hit;
    fire_left    = release_edge & armed_q;

    armed_d = armed_eff;
    if (fire_right || release_edge) begin
      armed_d = 1'b0;
    end
    stamp_d       = stamp_eff;
    prev_stable_d = stable;

    push_o.valid = accept_i & link_ready_i & (fire_right | fire_left);
    push_o.bits  = fire_right ? bclp_pkg::BTN_RIGHT : bclp_pkg::BTN_LEFT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b1;
      agree_q       <= '0;
      prev_stable_q <= 1'b1;
      armed_q       <= 1'b0;
      stamp_q       <= '0;
    end else if (accept_i) begin
      last_raw_q    <= last_raw_d;
      agree_q       <= agree_d;
      prev_stable_q <= prev_stable_d;
      armed_q       <= armed_d;
      stamp_q       <= stamp_d;
    end
  end

endmodule

FILE: rtl/bclp_queue.sv
// Two-entry event queue between the classifier and the report sequencer.
// Depends on bclp_pkg.
module bclp_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bclp_pkg::bclp_evt_t        push_i,
  input  logic                       pop_i,
  output bclp_pkg::bclp_evt_t        head_o,
  output logic                       full_o,
  output logic [bclp_pkg::Q_CNT_W-1:0] count_o
);

  logic [bclp_pkg::BTN_W-1:0]   entry_q [bclp_pkg::Q_DEPTH];
  logic [bclp_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [bclp_pkg::Q_CNT_W-1:0] count_q, count_d;
  logic                         do_push, do_pop;

  always_comb begin
    do_pop  = pop_i & (count_q != '0);
    do_push = push_i.valid & (count_q != bclp_pkg::Q_CNT_W'(bclp_pkg::Q_DEPTH));
    count_d = count_q + bclp_pkg::Q_CNT_W'(do_push) - bclp_pkg::Q_CNT_W'(do_pop);
    head_o.valid = count_q != '0;
    head_o.bits  = entry_q[rd_ptr_q];
    full_o  = count_q == bclp_pkg::Q_CNT_W'(bclp_pkg::Q_DEPTH);
    count_o = count_q;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/bclp_back.sv
// Report sequencer: turns each queued event into a press report and a release report.
// Depends on bclp_pkg.
module bclp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bclp_pkg::bclp_evt_t        head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bclp_pkg::BTN_W-1:0] button_bits_o,
  output logic                       final_report_o
);

  logic                       valid_q, valid_d;
  logic [bclp_pkg::BTN_W-1:0] bits_q, bits_d;
  logic                       final_q, final_d;
  logic                       advance;

  always_comb begin
    advance = ~valid_q | ~out_stall_i;
    valid_d = valid_q;
    bits_d  = bits_q;
    final_d = final_q;
    pop_o   = 1'b0;
    if (advance) begin
      if (valid_q && !final_q) begin
        valid_d = 1'b1;
        bits_d  = bclp_pkg::BTN_NONE;
        final_d = 1'b1;
      end else if (head_i.valid) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        bits_d  = head_i.bits;
        final_d = 1'b0;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      final_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

  assign out_valid_o    = valid_q;
  assign button_bits_o  = bits_q;
  assign final_report_o = final_q;

endmodule

FILE: rtl/button_click_long_press_qualifier.sv
// Top level of the button click and long-press qualifier.
// Depends on bclp_pkg, bclp_front, bclp_queue and bclp_back.
//
//   channel | handshake               | payload
//   poll in | in_valid_i / in_stall_o | raw_level_i, now_us_i, link_ready_i
//   report  | out_valid_o/out_stall_i | button_bits_o, final_report_o
//   config  | psel/penable/pwrite     | paddr, pwdata, prdata
//
// A poll is classified in the cycle it is accepted; one poll per cycle
// while in_stall_o is low. A click yields a press report and then a release
// report from the output register; out_stall_i holds the current report.
// in_stall_o rises only when the two-entry event queue is full.
// Reset clears debounce state, the queue and the output register.
module button_click_long_press_qualifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             raw_level_i,
  input  logic [bclp_pkg::TS_W-1:0]        now_us_i,
  input  logic                             link_ready_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bclp_pkg::BTN_W-1:0]       button_bits_o,
  output logic                             final_report_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bclp_pkg::PADDR_W-1:0]     paddr,
  input  logic [bclp_pkg::PDATA_W-1:0]     pwdata,
  output logic [bclp_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  logic [bclp_pkg::LPT_W-1:0]   lpt_q;
  logic [bclp_pkg::SN_W-1:0]    sn_q;
  logic                         cfg_wr;
  logic                         in_accept;
  logic                         pop;
  logic                         q_full;
  logic [bclp_pkg::Q_CNT_W-1:0] q_count;
  bclp_pkg::bclp_evt_t          push;
  bclp_pkg::bclp_evt_t          head;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign in_stall_o = q_full;
  assign in_accept = in_valid_i & ~q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpt_q <= bclp_pkg::LPT_RESET;
      sn_q  <= bclp_pkg::SN_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == bclp_pkg::REG_LPT) begin
        lpt_q <= pwdata[bclp_pkg::LPT_W-1:0];
      end else begin
        sn_q <= pwdata[bclp_pkg::SN_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == bclp_pkg::REG_LPT) begin
      prdata = {{(bclp_pkg::PDATA_W-bclp_pkg::LPT_W){1'b0}}, lpt_q};
    end else begin
      prdata = {{(bclp_pkg::PDATA_W-bclp_pkg::SN_W){1'b0}}, sn_q};
    end
  end

  bclp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_accept),
    .raw_level_i       (raw_level_i),
    .now_us_i          (now_us_i),
    .link_ready_i      (link_ready_i),
    .long_press_time_i (lpt_q),
    .stable_needed_i   (sn_q),
    .push_o            (push)
  );

  bclp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .count_o (q_count)
  );

  bclp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .button_bits_o  (button_bits_o),
    .final_report_o (final_report_o)
  );

  a_release_is_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_report_o |-> button_bits_o == bclp_pkg::BTN_NONE)
    else $error("release report carries button bits");

  a_press_then_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !final_report_o |=> out_valid_o && final_report_o)
    else $error("press report not followed by release");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= bclp_pkg::Q_CNT_W'(bclp_pkg::Q_DEPTH))
    else $error("event queue overflow");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push.valid)
    else $error("event pushed into full queue");

endmodule

FILE: sim/testbench.sv
// Testbench for button_click_long_press_qualifier: debounce, click and long-press reports.
// Predicts reports per accepted poll and checks them in order; needs bclp_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned STALL_PCT = 12;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [bclp_pkg::PADDR_W-1:0] ADDR_LPT = {bclp_pkg::REG_LPT, 2'b00};
  localparam logic [bclp_pkg::PADDR_W-1:0] ADDR_SN = {bclp_pkg::REG_SN, 2'b00};
  localparam logic [bclp_pkg::LPT_W-1:0] LPT_MAX = '1;

  typedef struct packed {
    logic [bclp_pkg::BTN_W-1:0] bits;
    logic                       closing;
  } report_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         raw_level_i = 1'b1;
  logic [bclp_pkg::TS_W-1:0]    now_us_i = '0;
  logic                         link_ready_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [bclp_pkg::BTN_W-1:0]   button_bits_o;
  logic                         final_report_o;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [bclp_pkg::PADDR_W-1:0] paddr = '0;
  logic [bclp_pkg::PDATA_W-1:0] pwdata = '0;
  logic [bclp_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  logic [bclp_pkg::LPT_W-1:0]   cfg_long_press = bclp_pkg::LPT_RESET;
  logic [bclp_pkg::SN_W-1:0]    cfg_stable_needed = bclp_pkg::SN_RESET;
  logic                         dbn_last_raw = 1'b1;
  logic [bclp_pkg::AGR_W-1:0]   dbn_count = '0;
  logic                         dbn_stable = 1'b1;
  logic                         press_armed = 1'b0;
  logic [bclp_pkg::TS_W-1:0]    press_stamp_us = '0;

  report_t                      pending_reports[$];
  logic [bclp_pkg::TS_W-1:0]    poll_clock_us = '0;
  int unsigned                  polls_sent = 0;
  int unsigned                  mismatches = 0;
  int unsigned                  quiet_cycles = 0;
  bit                           idle_en = 1'b1;

  button_click_long_press_qualifier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_level_i    (raw_level_i),
    .now_us_i       (now_us_i),
    .link_ready_i   (link_ready_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .button_bits_o  (button_bits_o),
    .final_report_o (final_report_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < 40) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
    mismatches++;
  endtask

  function automatic void predict_reports(input logic level,
                                          input logic [bclp_pkg::TS_W-1:0] stamp,
                                          input logic link);
    logic                       stable_now;
    logic                       clicked;
    logic [bclp_pkg::BTN_W-1:0] click;
    clicked = 1'b0;
    click = bclp_pkg::BTN_NONE;
    if (level == dbn_last_raw) begin
      if (dbn_count < bclp_pkg::AGREE_MAX) dbn_count++;
    end else begin
      dbn_count = '0;
      dbn_last_raw = level;
    end
    stable_now = (dbn_count >= cfg_stable_needed) ? dbn_last_raw : dbn_stable;
    if (dbn_stable && !stable_now) begin
      press_stamp_us = stamp;
      press_armed = 1'b1;
    end
    if (press_armed && !stable_now && (stamp - press_stamp_us) >= {16'b0, cfg_long_press}) begin
      if (link) begin
        clicked = 1'b1;
        click = bclp_pkg::BTN_RIGHT;
      end
      press_armed = 1'b0;
    end
    if (!dbn_stable && stable_now) begin
      if (press_armed && link) begin
        clicked = 1'b1;
        click = bclp_pkg::BTN_LEFT;
      end
      press_armed = 1'b0;
    end
    dbn_stable = stable_now;
    if (clicked) begin
      pending_reports.push_back(report_t'{click, 1'b0});
      pending_reports.push_back(report_t'{bclp_pkg::BTN_NONE, 1'b1});
    end
  endfunction

  task automatic send_poll(input logic level, input logic [bclp_pkg::TS_W-1:0] stamp,
                           input logic link);
    if (idle_en) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    raw_level_i <= level;
    now_us_i <= stamp;
    link_ready_i <= link;
    do @(posedge clk_i); while (in_stall_o);
    predict_reports(level, stamp, link);
    polls_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bclp_pkg::PADDR_W-1:0] addr,
                           input logic [bclp_pkg::PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_LPT) cfg_long_press = data[bclp_pkg::LPT_W-1:0];
    else cfg_stable_needed = data[bclp_pkg::SN_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [bclp_pkg::LPT_W-1:0] lpt,
                            input logic [bclp_pkg::SN_W-1:0] sn);
    settle();
    write_reg(ADDR_LPT, {{(bclp_pkg::PDATA_W-bclp_pkg::LPT_W){1'b0}}, lpt});
    write_reg(ADDR_SN, {{(bclp_pkg::PDATA_W-bclp_pkg::SN_W){1'b0}}, sn});
  endtask

  task automatic jump_clock();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    if ($urandom_range(1)) poll_clock_us = wide[bclp_pkg::TS_W-1:0];
    else poll_clock_us = '1 - bclp_pkg::TS_W'($urandom_range(2000000));
  endtask

  task automatic tick(input logic level, input logic link, input int unsigned step_max);
    poll_clock_us += bclp_pkg::TS_W'($urandom_range(step_max));
    send_poll(level, poll_clock_us, link);
  endtask

  // bounce, hold down, bounce, hold up
  task automatic random_gesture(input int unsigned step_max);
    logic link;
    link = ($urandom_range(9) != 0);
    if ($urandom_range(29) == 0) jump_clock();
    repeat ($urandom_range(2)) tick(1'($urandom_range(1)), link, step_max);
    repeat ($urandom_range(1, 10)) tick(1'b0, link, step_max);
    repeat ($urandom_range(2)) tick(1'($urandom_range(1)), link, step_max);
    repeat ($urandom_range(1, 6)) tick(1'b1, link, step_max);
  endtask

  task automatic test_click_and_long_press();
    send_poll(1'b0, 40'd0, 1'b1);
    send_poll(1'b0, 40'd1, 1'b1);
    send_poll(1'b0, 40'd2, 1'b1);
    send_poll(1'b1, 40'd3, 1'b1);
    send_poll(1'b1, 40'd4, 1'b1);
    send_poll(1'b1, 40'd5, 1'b1);
    // press just before the timestamp wraps, long press lands exactly on the limit
    send_poll(1'b0, 40'hFF_FFFF_FF00, 1'b1);
    send_poll(1'b0, 40'hFF_FFFF_FF10, 1'b1);
    send_poll(1'b0, 40'hFF_FFFF_FF20, 1'b1);
    send_poll(1'b0, 40'd499775, 1'b1);
    send_poll(1'b0, 40'd499776, 1'b1);
    send_poll(1'b1, 40'd499777, 1'b1);
    send_poll(1'b1, 40'd499778, 1'b1);
    send_poll(1'b1, 40'd499779, 1'b1);
  endtask

  task automatic test_link_down();
    send_poll(1'b0, 40'd1000, 1'b1);
    send_poll(1'b0, 40'd2000, 1'b1);
    send_poll(1'b0, 40'd3000, 1'b1);
    send_poll(1'b1, 40'd4000, 1'b0);
    send_poll(1'b1, 40'd5000, 1'b0);
    send_poll(1'b1, 40'd6000, 1'b0);
  endtask

  task automatic test_register_extremes();
    set_config('0, '0);
    send_poll(1'b0, 40'd0, 1'b1);
    send_poll(1'b1, '1, 1'b1);
    set_config(LPT_MAX, '0);
    send_poll(1'b0, 40'd10, 1'b1);
    send_poll(1'b1, 40'd20, 1'b1);
    set_config(LPT_MAX, '1);
    send_poll(1'b0, 40'd30, 1'b1);
    send_poll(1'b0, 40'd40, 1'b1);
    send_poll(1'b0, 40'd50, 1'b1);
    poll_clock_us = 40'd100;
  endtask

  task automatic test_random_phase(input logic [bclp_pkg::LPT_W-1:0] lpt,
                                   input logic [bclp_pkg::SN_W-1:0] sn,
                                   input int unsigned count);
    int unsigned target;
    int unsigned step_max;
    set_config(lpt, sn);
    step_max = lpt / 4 + 1;
    target = polls_sent + count;
    while (polls_sent < target) begin
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(9) == 0) jump_clock();
          tick(1'($urandom_range(1)), $urandom_range(3) != 0, step_max);
        end
      end else begin
        random_gesture(step_max);
      end
    end
  endtask

  task automatic test_random_configs(input int unsigned phases);
    logic [bclp_pkg::LPT_W-1:0] lpt;
    logic [bclp_pkg::SN_W-1:0]  sn;
    repeat (phases) begin
      case ($urandom_range(3))
        0: lpt = bclp_pkg::LPT_W'($urandom_range(1000));
        1: lpt = bclp_pkg::LPT_W'($urandom_range(500000));
        2: lpt = bclp_pkg::LPT_W'($urandom_range(LPT_MAX));
        default: lpt = $urandom_range(1) ? LPT_MAX : '0;
      endcase
      sn = ($urandom_range(7) == 0) ? '0 : bclp_pkg::SN_W'($urandom_range(1, 4));
      test_random_phase(lpt, sn, 140);
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random_phase(24'd200000, 3'd2, 140);
    idle_en = 1'b1;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= idle_en && ($urandom_range(99) < STALL_PCT);
  end

  always @(posedge clk_i) begin : check_reports
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("report with none pending", 0, 32'(button_bits_o));
      end else begin
        want = pending_reports.pop_front();
        if (button_bits_o !== want.bits)
          report_mismatch("button_bits", 32'(want.bits), 32'(button_bits_o));
        if (final_report_o !== want.closing)
          report_mismatch("final_report", 32'(want.closing), 32'(final_report_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_click_and_long_press();
    test_link_down();
    test_register_extremes();
    test_random_phase('0, '0, 150);
    test_random_phase(LPT_MAX, 3'd4, 100);
    test_random_phase(24'd1, 3'd1, 150);
    test_random_phase(24'd5000, 3'd7, 40);
    test_random_phase(24'd20000, 3'd5, 30);
    test_back_to_back();
    test_random_configs(6);
    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bclp_pkg.sv
rtl/bclp_front.sv
rtl/bclp_queue.sv
rtl/bclp_back.sv
rtl/button_click_long_press_qualifier.sv
sim/testbench.sv
